### rtl/merkle_root_sha256d_defines.svh
// Assertion macros used by the merkle root back end.
`ifndef MERKLE_ROOT_SHA256D_DEFINES_SVH
`define MERKLE_ROOT_SHA256D_DEFINES_SVH

// Same-cycle implication, checked on clk_i, idle during reset.
`define MRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk_i, idle during reset.
`define MRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/mrs_pkg.sv
// Shared types, constants and SHA-256 helpers for the merkle root block.
`default_nettype none
package mrs_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int IDX_W      = $clog2(MAX_LEAVES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NODE_W     = 256;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_MARK = 32'h80000000;

  typedef enum logic [1:0] {
    SHA_IDLE,
    SHA_LOAD,
    SHA_RND,
    SHA_ADD
  } sha_st_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RDL,
    B_RDR,
    B_CAPR,
    B_HASH,
    B_ONE,
    B_ONECAP,
    B_EMIT
  } back_st_e;

  typedef struct packed {
    logic [NODE_W-1:0] leaf;
    logic              no_leaf;
    logic              last;
  } leaf_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic              valid;
    logic              ovf;
  } res_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

### rtl/merkle_root_sha256d.sv
// Merkle root over double SHA-256: leaf queue, tree reducer and result register.
//
// Input queue: drive leaf_word0_i..3_i, no_leaf_i, last_leaf_i with push_i; a request
// is taken on a clock edge with push_i high and full_o low. A request with no_leaf_i
// high and last_leaf_i low is taken and does nothing. Leaves enter a four-entry queue
// and are written to the node memory one per cycle while the back end is idle.
// last_leaf_i ends the list; one result follows it on the output queue.
// Reduction: each pair is read from the node memory and hashed in the single SHA-256
// round unit (three compressions of 64 rounds, one load and one add each, then the done
// step); a level with an odd node count pairs its last node with itself. Each digest is
// written back into the node memory, and the last one is the root; one leaf is passed
// through as the root and an empty list gives a zero root.
// Output queue: root_word0_o..3_o, root_valid_o, overflow_o are held while empty_o is
// low and taken on an edge with pop_i high. While a result waits, new leaves are still
// taken until the queue fills; the next result waits for the register to empty.
// Reset (rst_ni low, asynchronous) empties both queues and clears the leaf count and
// flags; the node memory needs no clearing since only written entries are read.
`default_nettype none
module merkle_root_sha256d (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [63:0] leaf_word0_i,
  input  wire logic [63:0] leaf_word1_i,
  input  wire logic [63:0] leaf_word2_i,
  input  wire logic [63:0] leaf_word3_i,
  input  wire logic        no_leaf_i,
  input  wire logic        last_leaf_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic      [63:0] root_word0_o,
  output logic      [63:0] root_word1_o,
  output logic      [63:0] root_word2_o,
  output logic      [63:0] root_word3_o,
  output logic             root_valid_o,
  output logic             overflow_o
);

  mrs_pkg::leaf_req_t req, q_req;
  mrs_pkg::res_t      res, res_q;
  logic q_valid, q_pop, res_vld, full_q;

  assign req.leaf    = {leaf_word0_i, leaf_word1_i, leaf_word2_i, leaf_word3_i};
  assign req.no_leaf = no_leaf_i;
  assign req.last    = last_leaf_i;

  mrs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .req_i     (req),
    .q_valid_o (q_valid),
    .q_req_o   (q_req),
    .q_pop_i   (q_pop)
  );

  mrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .res_ready_i (!full_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (res_vld) begin
      full_q <= 1'b1;
    end else if (pop_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) res_q <= res;
  end

  assign empty_o      = !full_q;
  assign root_word0_o = res_q.root[255:192];
  assign root_word1_o = res_q.root[191:128];
  assign root_word2_o = res_q.root[127:64];
  assign root_word3_o = res_q.root[63:0];
  assign root_valid_o = res_q.valid;
  assign overflow_o   = res_q.ovf;

endmodule
`default_nettype wire

### rtl/mrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/mrs_sha.sv
// Double SHA-256 of a 64-byte pair, one round per cycle over three compressions.
`default_nettype none
module mrs_sha (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mrs_pkg::NODE_W-1:0] left_i,
  input  wire logic [mrs_pkg::NODE_W-1:0] right_i,
  output logic                            done_o,
  output logic      [mrs_pkg::NODE_W-1:0] digest_o
);

  mrs_pkg::sha_st_e st_q, st_d;
  logic [1:0]   phase_q;
  logic [5:0]   rnd_q;
  logic [511:0] msg_q;
  logic [31:0]  w_q [16];
  logic [31:0]  v_q [8];
  logic [31:0]  h_q [8];
  logic         done_q;

  logic [511:0] blk;
  logic [31:0]  t1, t2, w_new;
  logic         last_rnd;

  always_comb begin
    unique case (phase_q)
      2'd0:    blk = msg_q;
      2'd1:    blk = {mrs_pkg::PAD_MARK, 448'b0, 32'd512};
      default: blk = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7],
                      mrs_pkg::PAD_MARK, 192'b0, 32'd256};
    endcase
  end

  assign t1 = v_q[7] + mrs_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + mrs_pkg::SHA_K[rnd_q] + w_q[0];
  assign t2 = mrs_pkg::bsig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = mrs_pkg::ssig1(w_q[14]) + w_q[9] + mrs_pkg::ssig0(w_q[1]) + w_q[0];
  assign last_rnd = (rnd_q == 6'd63);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mrs_pkg::SHA_IDLE: if (start_i) st_d = mrs_pkg::SHA_LOAD;
      mrs_pkg::SHA_LOAD: st_d = mrs_pkg::SHA_RND;
      mrs_pkg::SHA_RND:  if (last_rnd) st_d = mrs_pkg::SHA_ADD;
      mrs_pkg::SHA_ADD:  st_d = (phase_q == 2'd2) ? mrs_pkg::SHA_IDLE : mrs_pkg::SHA_LOAD;
      default:           st_d = mrs_pkg::SHA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= mrs_pkg::SHA_IDLE;
      phase_q <= 2'd0;
      rnd_q   <= 6'd0;
      done_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == mrs_pkg::SHA_ADD) && (phase_q == 2'd2);
      if (st_q == mrs_pkg::SHA_IDLE && start_i) phase_q <= 2'd0;
      if (st_q == mrs_pkg::SHA_ADD) phase_q <= phase_q + 2'd1;
      if (st_q == mrs_pkg::SHA_LOAD) rnd_q <= 6'd0;
      else if (st_q == mrs_pkg::SHA_RND) rnd_q <= rnd_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      mrs_pkg::SHA_IDLE: begin
        if (start_i) msg_q <= {left_i, right_i};
      end
      mrs_pkg::SHA_LOAD: begin
        for (int k = 0; k < 16; k++) w_q[k] <= blk[511-32*k -: 32];
        for (int k = 0; k < 8; k++) begin
          v_q[k] <= (phase_q == 2'd1) ? h_q[k] : mrs_pkg::SHA_IV[k];
          h_q[k] <= (phase_q == 2'd1) ? h_q[k] : mrs_pkg::SHA_IV[k];
        end
      end
      mrs_pkg::SHA_RND: begin
        for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
        w_q[15] <= w_new;
        v_q[0] <= t1 + t2;
        v_q[1] <= v_q[0];
        v_q[2] <= v_q[1];
        v_q[3] <= v_q[2];
        v_q[4] <= v_q[3] + t1;
        v_q[5] <= v_q[4];
        v_q[6] <= v_q[5];
        v_q[7] <= v_q[6];
      end
      mrs_pkg::SHA_ADD: begin
        for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] + v_q[k];
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign digest_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule
`default_nettype wire

### rtl/mrs_front.sv
// Front end: accepts requests, drops empty non-final ones, queues the rest.
`default_nettype none
module mrs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire mrs_pkg::leaf_req_t req_i,
  output logic                    q_valid_o,
  output mrs_pkg::leaf_req_t      q_req_o,
  input  wire logic               q_pop_i
);

  mrs_pkg::leaf_req_t fifo_q [mrs_pkg::QDEPTH];
  logic [mrs_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [mrs_pkg::QPTR_W:0]   cnt_q;
  logic wr_en, rd_en;

  assign full_o    = (cnt_q == (mrs_pkg::QPTR_W+1)'(mrs_pkg::QDEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_req_o   = fifo_q[rd_q];
  // drop requests that carry nothing and end nothing
  assign wr_en = push_i && !full_o && !(req_i.no_leaf && !req_i.last);
  assign rd_en = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_q] <= req_i;
  end

endmodule
`default_nettype wire

### rtl/mrs_back.sv
// Back end: stores leaves and reduces the tree level by level into a root.
`default_nettype none
`include "merkle_root_sha256d_defines.svh"
module mrs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire mrs_pkg::leaf_req_t q_req_i,
  output logic                    q_pop_o,
  output logic                    res_vld_o,
  output mrs_pkg::res_t           res_o,
  input  wire logic               res_ready_i
);

  localparam int CW = mrs_pkg::CNT_W;
  localparam int IW = mrs_pkg::IDX_W;
  localparam int NW = mrs_pkg::NODE_W;

  mrs_pkg::back_st_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d;
  logic          dup_q, dup_d, ovf_q, ovf_d;
  logic [NW-1:0] left_q, left_d, root_q, root_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [NW-1:0] wdata, rdata;
  logic          sha_start, sha_done;
  logic [NW-1:0] digest;
  logic [CW-1:0] i_p1, i_p2, r_idx, n_half, cnt_inc;
  logic          store;

  mrs_ram #(.WIDTH(NW), .DEPTH(mrs_pkg::MAX_LEAVES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mrs_sha u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sha_start),
    .left_i   (left_q),
    .right_i  (rdata),
    .done_o   (sha_done),
    .digest_o (digest)
  );

  assign i_p1    = i_q + 1'b1;
  assign i_p2    = i_q + CW'(2);
  assign r_idx   = (i_p1 < n_q) ? i_p1 : i_q;
  assign n_half  = CW'((n_q + 1'b1) >> 1);
  assign store   = !q_req_i.no_leaf && (cnt_q < CW'(mrs_pkg::MAX_LEAVES));
  assign cnt_inc = cnt_q + CW'(store);

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    i_d       = i_q;
    dup_d     = dup_q;
    ovf_d     = ovf_q;
    left_d    = left_q;
    root_d    = root_q;
    q_pop_o   = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[IW-1:0];
    wdata     = q_req_i.leaf;
    raddr     = i_q[IW-1:0];
    sha_start = 1'b0;
    res_vld_o = 1'b0;
    unique case (st_q)
      mrs_pkg::B_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          we    = store;
          cnt_d = cnt_inc;
          if (!q_req_i.no_leaf && !store) ovf_d = 1'b1;
          if (q_req_i.last) begin
            priority if (cnt_inc == '0) begin
              root_d = '0;
              st_d   = mrs_pkg::B_EMIT;
            end else if (cnt_inc == CW'(1)) begin
              st_d = mrs_pkg::B_ONE;
            end else begin
              n_d  = cnt_inc;
              i_d  = '0;
              st_d = mrs_pkg::B_RDL;
            end
          end
        end
      end
      mrs_pkg::B_RDL: st_d = mrs_pkg::B_RDR;
      mrs_pkg::B_RDR: begin
        raddr  = r_idx[IW-1:0];
        left_d = rdata;
        st_d   = mrs_pkg::B_CAPR;
      end
      mrs_pkg::B_CAPR: begin
        // flag a duplicated final pair on an even level
        if (r_idx != i_q && i_p2 == n_q && left_q == rdata) dup_d = 1'b1;
        sha_start = 1'b1;
        st_d      = mrs_pkg::B_HASH;
      end
      mrs_pkg::B_HASH: begin
        if (sha_done) begin
          we    = 1'b1;
          waddr = i_q[IW:1];
          wdata = digest;
          if (i_p2 >= n_q) begin
            i_d = '0;
            n_d = n_half;
            if (n_half == CW'(1)) begin
              root_d = digest;
              st_d   = mrs_pkg::B_EMIT;
            end else begin
              st_d = mrs_pkg::B_RDL;
            end
          end else begin
            i_d  = i_p2;
            st_d = mrs_pkg::B_RDL;
          end
        end
      end
      mrs_pkg::B_ONE: begin
        raddr = '0;
        st_d  = mrs_pkg::B_ONECAP;
      end
      mrs_pkg::B_ONECAP: begin
        root_d = rdata;
        st_d   = mrs_pkg::B_EMIT;
      end
      mrs_pkg::B_EMIT: begin
        res_vld_o = res_ready_i;
        if (res_ready_i) begin
          cnt_d = '0;
          dup_d = 1'b0;
          ovf_d = 1'b0;
          st_d  = mrs_pkg::B_IDLE;
        end
      end
      default: st_d = mrs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mrs_pkg::B_IDLE;
      cnt_q <= '0;
      n_q   <= '0;
      i_q   <= '0;
      dup_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      n_q   <= n_d;
      i_q   <= i_d;
      dup_q <= dup_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    root_q <= root_d;
  end

  assign res_o.root  = root_q;
  assign res_o.valid = !dup_q;
  assign res_o.ovf   = ovf_q;

  `MRS_ASSERT_IMP(a_done_in_hash, sha_done, st_q == mrs_pkg::B_HASH)
  `MRS_ASSERT_IMP(a_res_has_room, res_vld_o, res_ready_i)
  `MRS_ASSERT_IMP(a_pair_in_level, st_q == mrs_pkg::B_RDL, i_q < n_q && n_q > CW'(1))
  `MRS_ASSERT_NXT(a_start_to_hash, sha_start, st_q == mrs_pkg::B_HASH)

endmodule
`default_nettype wire
